// File: src/gcib_pkg.sv
// gcib_pkg: shared constants, fixed-point widths and the cordic arctangent table
// for the great-circle initial bearing unit; no dependencies
package gcib_pkg;

    localparam int DEF_CORDIC_STAGES   = 24;
    localparam int DEF_ANGLE_FRAC_BITS = 23;
    localparam int IN_FRAC             = 23;
    localparam int TRIG_FRAC           = 30;
    localparam int TRIG_W              = 33;
    localparam int VEC_W               = 35;
    localparam int CORDIC_GAIN_Q30     = 652032874;
    localparam int FULL_TURN_DEG       = 360;

    // atan(2^-i) in degrees, 23 fraction bits
    localparam int ATAN_TAB [0:31] = '{
        377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
        7509261, 3754860, 1877459, 938733, 469367, 234683, 117342, 58671,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0
    };

    // table entry rounded half up to frac fraction bits
    function automatic int atan_ent(int i, int frac);
        int s;
        int half;
        s    = IN_FRAC - frac;
        half = (1 << s) >> 1;
        return (ATAN_TAB[i & 31] + half) >>> s;
    endfunction

endpackage

// File: src/gcib_sincos.sv
// gcib_sincos: pipelined rotation cordic giving sine and cosine of an angle in degrees
// depends on gcib_pkg
module gcib_sincos
    import gcib_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int FRAC   = DEF_ANGLE_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  logic                     in_vld,
    input  logic signed [FRAC+9:0]   ang,
    output logic                     out_vld,
    output logic signed [TRIG_W-1:0] sin_o,
    output logic signed [TRIG_W-1:0] cos_o
);

    localparam int AW = FRAC + 10;
    localparam logic signed [AW-1:0] D90  = AW'(longint'(90) << FRAC);
    localparam logic signed [AW-1:0] D180 = AW'(longint'(180) << FRAC);

    logic                     vld_reg [0:STAGES+1];
    logic signed [TRIG_W-1:0] x_reg   [0:STAGES];
    logic signed [TRIG_W-1:0] y_reg   [0:STAGES];
    logic signed [AW-1:0]     z_reg   [0:STAGES];
    logic                     neg_reg [0:STAGES];
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    // reduction modulo a full turn, then fold into [-90,90]
    logic signed [9:0]    q;
    logic signed [11:0]   t;
    logic [10:0]          t1;
    logic [10:0]          m;
    logic signed [9:0]    mi;
    logic signed [AW-1:0] v;
    logic signed [AW-1:0] z_next;
    logic                 neg_next;

    always_comb
    begin
        q  = ang[AW-1:FRAC];
        t  = 12'(q) + 12'sd720;
        t1 = (t >= 12'sd720) ? 11'(t - 12'sd720) : 11'(t);
        m  = (t1 >= 11'd360) ? 11'(t1 - 11'd360) : t1;
        mi = (m >= 11'd180) ? 10'(m - 11'd360) : 10'(m);
        v  = {mi, ang[FRAC-1:0]};
        neg_next = 1'b0;
        z_next   = v;
        if (v > D90)
        begin
            z_next   = v - D180;
            neg_next = 1'b1;
        end
        else if (v < -D90)
        begin
            z_next   = v + D180;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]   <= TRIG_W'(CORDIC_GAIN_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        localparam logic signed [AW-1:0] ATN = AW'(atan_ent(i, FRAC));
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATN;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cos_reg <= neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            sin_reg <= neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign out_vld = vld_reg[STAGES+1];
    assign sin_o   = sin_reg;
    assign cos_o   = cos_reg;

endmodule

// File: src/gcib_atan2.sv
// gcib_atan2: pipelined vectoring cordic for atan2 with wrap into [0,360) degrees
// depends on gcib_pkg
module gcib_atan2
    import gcib_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int FRAC   = DEF_ANGLE_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_vld,
    input  logic signed [VEC_W-1:0] y_i,
    input  logic signed [VEC_W-1:0] x_i,
    output logic                    out_vld,
    output logic [31:0]             bearing_o
);

    localparam int AW = FRAC + 10;
    localparam int W  = VEC_W + 2;
    localparam int SH = IN_FRAC - FRAC;
    localparam logic signed [AW-1:0] D180 = AW'(longint'(180) << FRAC);
    localparam logic signed [AW-1:0] FULL = AW'(longint'(FULL_TURN_DEG) << FRAC);

    logic                vld_reg  [0:STAGES+1];
    logic signed [W-1:0] x_reg    [0:STAGES];
    logic signed [W-1:0] y_reg    [0:STAGES];
    logic signed [AW-1:0] z_reg   [0:STAGES];
    logic                zero_reg [0:STAGES];
    logic [31:0]         bearing_reg;

    logic signed [W-1:0] xw;
    logic signed [W-1:0] yw;
    logic signed [AW-1:0] zf;
    logic signed [AW-1:0] w1;
    logic signed [AW-1:0] w2;

    assign xw = W'(x_i);
    assign yw = W'(y_i);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // left half plane starts from +-180
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zero_reg[0] <= (x_i == '0) && (y_i == '0);
            if (xw < 0)
            begin
                x_reg[0] <= -xw;
                y_reg[0] <= -yw;
                z_reg[0] <= (yw >= 0) ? D180 : -D180;
            end
            else
            begin
                x_reg[0] <= xw;
                y_reg[0] <= yw;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_vec
        localparam logic signed [AW-1:0] ATN = AW'(atan_ent(i, FRAC));
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATN;
                end
            end
        end
    end

    // wrap into [0,360)
    always_comb
    begin
        zf = z_reg[STAGES];
        w1 = (zf < 0) ? zf + FULL : zf;
        w2 = (w1 >= FULL) ? w1 - FULL : w1;
        if (w2 < 0 || zero_reg[STAGES])
        begin
            w2 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bearing_reg <= 32'($unsigned(w2)) << SH;
        end
    end

    assign out_vld   = vld_reg[STAGES+1];
    assign bearing_o = bearing_reg;

endmodule

// File: src/great_circle_initial_bearing_unit.sv
// great_circle_initial_bearing_unit: top level, input register, three sine/cosine
// pipelines, product stages and the atan2 pipeline; depends on gcib_pkg,
// gcib_sincos and gcib_atan2
//
// channel  signals                                         dir
// input    in_valid, in_ready, start_lat, start_lon,       in
//          end_lat, end_lon
// output   out_valid, out_ready, bearing                   out
//
// one transaction in per cycle while the pipeline is not held, one bearing out per transaction
// the two cordic pipelines run in series
// reset clears only the valid bits of every stage
// the whole pipeline holds while a bearing waits and out_ready is low
module great_circle_initial_bearing_unit
    import gcib_pkg::*;
#(
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] start_lat,
    input  logic signed [31:0] start_lon,
    input  logic signed [30:0] end_lat,
    input  logic signed [31:0] end_lon,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        bearing
);

    localparam int AW = ANGLE_FRAC_BITS + 10;
    localparam int SH = IN_FRAC - ANGLE_FRAC_BITS;

    logic ce;

    logic signed [30:0] lat1_sh;
    logic signed [30:0] lat2_sh;
    logic signed [32:0] dlon_full;
    logic signed [32:0] dlon_sh;

    logic                 in_vld_reg;
    logic signed [AW-1:0] lat1_reg;
    logic signed [AW-1:0] lat2_reg;
    logic signed [AW-1:0] dlon_reg;

    logic                     sc_vld;
    logic signed [TRIG_W-1:0] s1;
    logic signed [TRIG_W-1:0] c1;
    logic signed [TRIG_W-1:0] s2;
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] sd;
    logic signed [TRIG_W-1:0] cd;

    logic signed [2*TRIG_W-1:0] py;
    logic signed [2*TRIG_W-1:0] pa;
    logic signed [2*TRIG_W-1:0] pb;
    logic signed [2*TRIG_W-1:0] pq;

    logic [2:0]               p_vld_reg;
    logic signed [VEC_W-1:0]  y1_reg;
    logic signed [VEC_W-1:0]  a1_reg;
    logic signed [TRIG_W-1:0] b1_reg;
    logic signed [TRIG_W-1:0] cd1_reg;
    logic signed [VEC_W-1:0]  y2_reg;
    logic signed [VEC_W-1:0]  a2_reg;
    logic signed [VEC_W-1:0]  q2_reg;
    logic signed [VEC_W-1:0]  y3_reg;
    logic signed [VEC_W-1:0]  x3_reg;

    assign ce       = out_ready || !out_valid;
    assign in_ready = ce;

    assign lat1_sh   = start_lat >>> SH;
    assign lat2_sh   = end_lat >>> SH;
    assign dlon_full = 33'(end_lon) - 33'(start_lon);
    assign dlon_sh   = dlon_full >>> SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            p_vld_reg  <= '0;
        end
        else if (ce)
        begin
            in_vld_reg <= in_valid;
            p_vld_reg  <= {p_vld_reg[1:0], sc_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lat1_reg <= AW'(lat1_sh);
            lat2_reg <= AW'(lat2_sh);
            dlon_reg <= AW'(dlon_sh);
        end
    end

    gcib_sincos #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_sc_lat1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (in_vld_reg),
        .ang     (lat1_reg),
        .out_vld (),
        .sin_o   (s1),
        .cos_o   (c1)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_sc_lat2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (in_vld_reg),
        .ang     (lat2_reg),
        .out_vld (),
        .sin_o   (s2),
        .cos_o   (c2)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_sc_dlon (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_vld  (in_vld_reg),
        .ang     (dlon_reg),
        .out_vld (sc_vld),
        .sin_o   (sd),
        .cos_o   (cd)
    );

    // products floored back to 30 fraction bits
    assign py = sd * c2;
    assign pa = c1 * s2;
    assign pb = s1 * c2;
    assign pq = b1_reg * cd1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            y1_reg  <= VEC_W'(py >>> TRIG_FRAC);
            a1_reg  <= VEC_W'(pa >>> TRIG_FRAC);
            b1_reg  <= TRIG_W'(pb >>> TRIG_FRAC);
            cd1_reg <= cd;
            y2_reg  <= y1_reg;
            a2_reg  <= a1_reg;
            q2_reg  <= VEC_W'(pq >>> TRIG_FRAC);
            y3_reg  <= y2_reg;
            x3_reg  <= a2_reg - q2_reg;
        end
    end

    gcib_atan2 #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_atan2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_vld    (p_vld_reg[2]),
        .y_i       (y3_reg),
        .x_i       (x3_reg),
        .out_vld   (out_valid),
        .bearing_o (bearing)
    );

endmodule

// File: verif/tb_great_circle_initial_bearing_unit.sv
// tb_great_circle_initial_bearing_unit: self-checking testbench for the great-circle
// initial bearing unit; predicts each bearing with a fixed-point cordic model of its own
// depends on gcib_pkg and great_circle_initial_bearing_unit
`timescale 1ns / 100ps

module tb_great_circle_initial_bearing_unit;
    import gcib_pkg::*;

    localparam int STAGES    = DEF_CORDIC_STAGES;
    localparam int FRAC      = DEF_ANGLE_FRAC_BITS;
    localparam int LATENCY   = 2 * STAGES + 8;
    localparam int WDOG_MAX  = 20000;
    localparam int RAND_ITEMS = 580;
    localparam logic signed [30:0] LAT_MAX = 31'sd754974720;
    localparam logic signed [31:0] LON_MAX = 32'sd1509949440;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [30:0] start_lat = '0;
    logic signed [31:0] start_lon = '0;
    logic signed [30:0] end_lat = '0;
    logic signed [31:0] end_lon = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        bearing;

    logic [31:0] bearing_queue [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    great_circle_initial_bearing_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_lat (start_lat),
        .start_lon (start_lon),
        .end_lat   (end_lat),
        .end_lon   (end_lon),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bearing   (bearing)
    );

    always #5 clk = ~clk;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint half;
        half = (longint'(1) << (IN_FRAC - FRAC)) >> 1;
        return (longint'(ATAN_TAB[i]) + half) >>> (IN_FRAC - FRAC);
    endfunction

    function automatic longint degrees(longint d);
        return d * (longint'(1) << FRAC);
    endfunction

    // rotation-mode cordic, angle in degrees, result in q30
    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint full;
        longint x;
        longint y;
        longint t;
        bit     flip;
        full = degrees(FULL_TURN_DEG);
        x    = CORDIC_GAIN_Q30;
        y    = 0;
        flip = 1'b0;
        ang  = ang % full;
        if (ang < 0)
            ang += full;
        if (ang >= full / 2)
            ang -= full;
        if (ang > degrees(90))
        begin
            ang -= degrees(180);
            flip = 1'b1;
        end
        else if (ang < -degrees(90))
        begin
            ang += degrees(180);
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            t = x;
            if (ang >= 0)
            begin
                x = x - floor_shr(y, i);
                y = y + floor_shr(t, i);
                ang -= atan_step(i);
            end
            else
            begin
                x = x + floor_shr(y, i);
                y = y - floor_shr(t, i);
                ang += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? degrees(180) : -degrees(180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            t = x;
            if (y > 0)
            begin
                x = x + floor_shr(y, i);
                y = y - floor_shr(t, i);
                z += atan_step(i);
            end
            else
            begin
                x = x - floor_shr(y, i);
                y = y + floor_shr(t, i);
                z -= atan_step(i);
            end
        end
        return z;
    endfunction

    task automatic predict_bearing(input logic signed [30:0] lat_a,
                                   input logic signed [31:0] lon_a,
                                   input logic signed [30:0] lat_b,
                                   input logic signed [31:0] lon_b,
                                   output logic [31:0] result);
        int     sh;
        longint s1, c1, s2, c2, sd, cd, y, x, z, full;
        sh   = IN_FRAC - FRAC;
        full = degrees(FULL_TURN_DEG);
        sin_cos(floor_shr(longint'(lat_a), sh), s1, c1);
        sin_cos(floor_shr(longint'(lat_b), sh), s2, c2);
        sin_cos(floor_shr(longint'(lon_b) - longint'(lon_a), sh), sd, cd);
        y = floor_shr(sd * c2, TRIG_FRAC);
        x = floor_shr(c1 * s2, TRIG_FRAC)
            - floor_shr(floor_shr(s1 * c2, TRIG_FRAC) * cd, TRIG_FRAC);
        if (x == 0 && y == 0)
            z = 0;
        else
        begin
            z = vector_angle(y, x);
            if (z < 0)
                z += full;
            if (z >= full)
                z -= full;
            if (z < 0)
                z = 0;
        end
        result = 32'(z << sh);
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic send_position(input logic signed [30:0] lat_a,
                                 input logic signed [31:0] lon_a,
                                 input logic signed [30:0] lat_b,
                                 input logic signed [31:0] lon_b,
                                 input bit may_idle);
        logic [31:0] expected;
        int          gap;
        gap = may_idle ? random_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        predict_bearing(lat_a, lon_a, lat_b, lon_b, expected);
        start_lat <= lat_a;
        start_lon <= lon_a;
        end_lat   <= lat_b;
        end_lon   <= lon_b;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bearing_queue.push_back(expected);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (bearing_queue.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'($signed($urandom_range(0, 2 * 754974720)) - 754974720);
    endfunction

    function automatic logic signed [31:0] rand_lon();
        return 32'(longint'($urandom_range(0, 32'hB4000000)) - 1509949440);
    endfunction

    task automatic test_directed();
        send_position('0, '0, '0, '0, 1'b0);
        send_position('0, '0, LAT_MAX, '0, 1'b0);
        send_position('0, '0, -LAT_MAX, '0, 1'b0);
        send_position('0, '0, '0, 32'sd754974720, 1'b0);
        send_position('0, '0, '0, -32'sd754974720, 1'b0);
        send_position(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 1'b0);
        send_position(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1'b0);
        send_position(LAT_MAX, '0, LAT_MAX, 32'sd8388608, 1'b0);
        send_position(31'sd100, 32'sd5, 31'sd100, 32'sd5, 1'b0);
        send_position('0, '0, '0, LON_MAX, 1'b0);
        // out of nominal range: full bit patterns; then two routes in range
        send_position(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000, 1'b0);
        send_position(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_position(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h55555555, 32'hAAAAAAAA, 1'b0);
        send_position(31'h2AAAAAAA, 32'h55555555, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_position(-LAT_MAX, '0, LAT_MAX, '0, 1'b0);
        send_position(31'sd377487360, 32'sd1000, -31'sd377487360, -32'sd1000, 1'b0);
    endtask

    task automatic test_random_routes();
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 2)
                wait_drained();
            if ($urandom_range(0, 9) == 0)
                send_position(31'($urandom), 32'($urandom), 31'($urandom), 32'($urandom),
                              1'b1);
            else if ($urandom_range(0, 9) == 0)
            begin
                logic signed [30:0] la;
                logic signed [31:0] lo;
                la = rand_lat();
                lo = rand_lon();
                send_position(la, lo, la + 31'($signed($urandom_range(0, 64)) - 32),
                              lo + 32'($signed($urandom_range(0, 64)) - 32), 1'b1);
            end
            else
                send_position(rand_lat(), rand_lon(), rand_lat(), rand_lon(), 1'b1);
        end
    endtask

    // result checker with random stall on the receive side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (bearing_queue.size() == 0)
            begin
                $error("bearing: unexpected transaction, actual %0d", bearing);
                error_count++;
            end
            else
            begin
                logic [31:0] exp_b;
                exp_b = bearing_queue.pop_front();
                if (bearing !== exp_b)
                begin
                    $error("bearing: expected %0d actual %0d", exp_b, bearing);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int hold;
        if (rst_n)
        begin
            hold = random_gap();
            if (hold == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_routes();
        wait_drained();
        repeat (LATENCY) @(negedge clk);
        if (error_count == 0 && bearing_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
